/* rtl/core/left_to_right_expression_evaluator_top_defines.svh */
// Assertion macros for the left-to-right expression evaluator.
`ifndef LEFT_TO_RIGHT_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define LEFT_TO_RIGHT_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LTR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ltr_eval_pkg.sv */
// Types and constants shared by the left-to-right expression evaluator.
`timescale 1ns / 1ps

package ltr_eval_pkg;

    localparam int VALUE_BITS = 48;

    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] DIGIT_BASE = 8'd48;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_STAR    = 8'd42;
    localparam logic [7:0] CH_SLASH   = 8'd47;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         div_zero;
        logic                         overflowed;
    } t_out_word;

endpackage

/* rtl/core/left_to_right_expression_evaluator_top.sv */
// Left-to-right expression evaluator: characters in, one fixed-point result per expression out.
`timescale 1ns / 1ps
`include "left_to_right_expression_evaluator_top_defines.svh"

// Each input word carries one ASCII character; digits build the current operand and the
// operators + - * / are applied strictly left to right, while every other character is
// ignored. The word flagged as last produces one output word holding the value in signed
// fixed point with FRAC_BITS fraction bits, plus sticky divide-by-zero and saturation flags,
// after which the evaluator starts a fresh expression. All arithmetic runs through one shared
// adder under a small sequencer, so the input side is busy while a character is worked on.
// Every character passes through a check state; a digit first goes through the multiply-by-ten
// and add-digit accumulate steps, and a character that applies a pending add or subtract then
// takes the add/subtract step. Applying a multiply or divide instead takes the magnitude steps,
// the one-bit-per-cycle shift-add or restoring-divide loop, and the saturate and sign steps; a
// divide by zero ends after the magnitude steps. The last word of an expression then passes
// the output state, where it waits while the previous result still waits.
// The output register lets the next expression start while the previous result is still waiting.
module left_to_right_expression_evaluator_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  ltr_eval_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output ltr_eval_pkg::t_out_word o_out_word
);
    import ltr_eval_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int MW = (VB > FRAC_BITS + 4) ? VB : FRAC_BITS + 4;
    localparam int AW = MW + 5;
    localparam int DW = VB + FRAC_BITS;
    localparam int XW = (DW > 2 * VB) ? DW : 2 * VB;
    localparam int CW = $clog2(DW + 1);

    localparam logic [AW-1:0] MAX_A   = {{(AW-VB+1){1'b0}}, {(VB-1){1'b1}}};
    localparam logic [AW-1:0] MIN_A   = {{(AW-VB+1){1'b1}}, {(VB-1){1'b0}}};
    localparam logic [VB-1:0] MAX_V   = MAX_A[VB-1:0];
    localparam logic [VB-1:0] MIN_V   = MIN_A[VB-1:0];
    localparam logic [XW-1:0] LIM_POS = XW'(MAX_V);
    localparam logic [XW-1:0] LIM_NEG = XW'(MIN_V);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ACC_MUL = 4'd1;
    localparam logic [3:0] S_ACC_ADD = 4'd2;
    localparam logic [3:0] S_CHECK   = 4'd3;
    localparam logic [3:0] S_ADDSUB  = 4'd4;
    localparam logic [3:0] S_MAG_A   = 4'd5;
    localparam logic [3:0] S_MAG_B   = 4'd6;
    localparam logic [3:0] S_MUL     = 4'd7;
    localparam logic [3:0] S_DIV     = 4'd8;
    localparam logic [3:0] S_SAT     = 4'd9;
    localparam logic [3:0] S_NEG     = 4'd10;
    localparam logic [3:0] S_OUT     = 4'd11;

    logic [3:0]    r_state, n_state;
    logic          r_left_started, n_left_started;
    logic          r_left_closed, n_left_closed;
    logic [2:0]    r_pending, n_pending;
    logic [2:0]    r_queued, n_queued;
    logic [VB-1:0] r_left, n_left;
    logic [VB-1:0] r_right, n_right;
    logic          r_dz, n_dz;
    logic          r_ovf, n_ovf;
    logic          r_out_valid, n_out_valid;
    logic          r_last, n_last;
    logic          r_trig, n_trig;
    logic          r_neg, n_neg;
    logic [3:0]    r_digit, n_digit;
    logic [VB-1:0] r_a, n_a;
    logic [VB-1:0] r_b, n_b;
    logic [VB:0]   r_hi, n_hi;
    logic [XW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_cnt, n_cnt;
    t_out_word     r_out, n_out;

    logic [AW-1:0]   add_x, add_y, add_s;
    logic            add_sub;
    logic            sat_hi, sat_lo;
    logic [VB-1:0]   add_clamp;
    logic [VB-1:0]   tgt;
    logic [VB-1:0]   mag_now;
    logic [VB:0]     rem_sh;
    logic            borrow;
    logic [2*VB-1:0] prod;
    logic [XW-1:0]   cand, lim;
    logic [7:0]      in_code;
    logic            in_digit;
    logic [2:0]      in_op;
    logic            out_load;

    function automatic logic [AW-1:0] sext(input logic [VB-1:0] v);
        return {{(AW-VB){v[VB-1]}}, v};
    endfunction

    assign tgt    = r_left_closed ? r_right : r_left;
    assign rem_sh = {r_hi[VB-1:0], r_lo[DW-1]};
    assign prod   = {r_hi[VB-1:0], r_lo[VB-1:0]};
    assign cand   = (r_pending == OP_MUL) ? XW'(prod >> FRAC_BITS) : r_lo;
    assign lim    = r_neg ? LIM_NEG : LIM_POS;

    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (r_state)
            S_ACC_MUL: begin
                add_x = sext(tgt) << 3;
                add_y = sext(tgt) << 1;
            end
            S_ACC_ADD: begin
                add_x = sext(tgt);
                add_y = AW'(r_digit) << FRAC_BITS;
            end
            S_ADDSUB: begin
                add_x   = sext(r_left);
                add_y   = sext(r_right);
                add_sub = (r_pending == OP_SUB);
            end
            S_MAG_A: begin
                add_y   = sext(r_left);
                add_sub = 1'b1;
            end
            S_MAG_B: begin
                add_y   = sext(r_right);
                add_sub = 1'b1;
            end
            S_MUL: begin
                add_x = AW'(r_hi);
                add_y = r_lo[0] ? AW'(r_a) : '0;
            end
            S_DIV: begin
                add_x   = AW'(rem_sh);
                add_y   = AW'(r_b);
                add_sub = 1'b1;
            end
            S_NEG: begin
                add_y   = AW'(r_a);
                add_sub = r_neg;
            end
            default: begin
                add_x = '0;
            end
        endcase
    end

    assign add_s     = add_x + (add_sub ? ~add_y : add_y) + AW'(add_sub);
    assign sat_hi    = $signed(add_s) > $signed(MAX_A);
    assign sat_lo    = $signed(add_s) < $signed(MIN_A);
    assign add_clamp = sat_hi ? MAX_V : (sat_lo ? MIN_V : add_s[VB-1:0]);
    assign borrow    = add_s[AW-1];

    always_comb begin
        mag_now = r_left;
        if (r_state == S_MAG_B) begin
            mag_now = r_right[VB-1] ? add_s[VB-1:0] : r_right;
        end else if (r_left[VB-1]) begin
            mag_now = add_s[VB-1:0];
        end
    end

    assign in_code  = i_in_word.char_code;
    assign in_digit = (in_code >= CH_ZERO) && (in_code <= CH_NINE);

    always_comb begin
        case (in_code)
            CH_PLUS:  in_op = OP_ADD;
            CH_MINUS: in_op = OP_SUB;
            CH_STAR:  in_op = OP_MUL;
            CH_SLASH: in_op = OP_DIV;
            default:  in_op = OP_NONE;
        endcase
    end

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state        = r_state;
        n_left_started = r_left_started;
        n_left_closed  = r_left_closed;
        n_pending      = r_pending;
        n_queued       = r_queued;
        n_left         = r_left;
        n_right        = r_right;
        n_dz           = r_dz;
        n_ovf          = r_ovf;
        n_last         = r_last;
        n_trig         = r_trig;
        n_neg          = r_neg;
        n_digit        = r_digit;
        n_a            = r_a;
        n_b            = r_b;
        n_hi           = r_hi;
        n_lo           = r_lo;
        n_cnt          = r_cnt;
        n_out          = r_out;
        n_out_valid    = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last  = i_in_word.last_char;
                    n_trig  = i_in_word.last_char;
                    n_digit = 4'(in_code - DIGIT_BASE);
                    n_state = S_CHECK;
                    if (in_digit) begin
                        n_state = S_ACC_MUL;
                        if (!r_left_closed) begin
                            n_left_started = 1'b1;
                        end
                    end else if (in_op != OP_NONE) begin
                        if (r_left_closed) begin
                            n_trig = 1'b1;
                        end else begin
                            n_left_closed = 1'b1;
                        end
                        if (r_pending != OP_NONE) begin
                            n_queued = in_op;
                        end else begin
                            n_pending = in_op;
                        end
                    end
                end
            end
            S_ACC_MUL, S_ACC_ADD: begin
                n_ovf = r_ovf | sat_hi | sat_lo;
                if (r_left_closed) begin
                    n_right = add_clamp;
                end else begin
                    n_left = add_clamp;
                end
                n_state = (r_state == S_ACC_MUL) ? S_ACC_ADD : S_CHECK;
            end
            S_CHECK: begin
                n_state = r_last ? S_OUT : S_IDLE;
                if (r_left_started && r_trig) begin
                    case (r_pending)
                        OP_ADD, OP_SUB: n_state = S_ADDSUB;
                        OP_MUL, OP_DIV: n_state = S_MAG_A;
                        default:        n_state = r_last ? S_OUT : S_IDLE;
                    endcase
                end
            end
            S_ADDSUB: begin
                n_ovf     = r_ovf | sat_hi | sat_lo;
                n_left    = add_clamp;
                n_pending = r_queued;
                n_right   = '0;
                n_state   = r_last ? S_OUT : S_IDLE;
            end
            S_MAG_A: begin
                n_a     = mag_now;
                n_state = S_MAG_B;
            end
            S_MAG_B: begin
                n_b   = mag_now;
                n_neg = r_left[VB-1] ^ r_right[VB-1];
                n_hi  = '0;
                n_cnt = '0;
                if (r_pending == OP_MUL) begin
                    n_lo    = XW'(mag_now);
                    n_state = S_MUL;
                end else if (r_right == '0) begin
                    n_dz      = 1'b1;
                    n_left    = (r_a == '0) ? '0 : (r_left[VB-1] ? MIN_V : MAX_V);
                    n_pending = r_queued;
                    n_right   = '0;
                    n_state   = r_last ? S_OUT : S_IDLE;
                end else begin
                    n_lo    = XW'(r_a) << FRAC_BITS;
                    n_state = S_DIV;
                end
            end
            S_MUL: begin
                n_hi                = {1'b0, add_s[VB:1]};
                n_lo                = XW'({add_s[0], r_lo[VB-1:1]});
                n_cnt               = r_cnt + 1'b1;
                if (r_cnt == CW'(VB - 1)) begin
                    n_state = S_SAT;
                end
            end
            S_DIV: begin
                n_hi  = borrow ? rem_sh : add_s[VB:0];
                n_lo  = XW'({r_lo[DW-2:0], ~borrow});
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                if (cand > lim) begin
                    n_ovf = 1'b1;
                    n_a   = lim[VB-1:0];
                end else begin
                    n_a = cand[VB-1:0];
                end
                n_state = S_NEG;
            end
            S_NEG: begin
                n_left    = add_s[VB-1:0];
                n_pending = r_queued;
                n_right   = '0;
                n_state   = r_last ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (out_load) begin
                    n_out.value      = r_left;
                    n_out.div_zero   = r_dz;
                    n_out.overflowed = r_ovf;
                    n_out_valid      = 1'b1;
                    n_left_started   = 1'b0;
                    n_left_closed    = 1'b0;
                    n_pending        = OP_NONE;
                    n_queued         = OP_NONE;
                    n_left           = '0;
                    n_right          = '0;
                    n_dz             = 1'b0;
                    n_ovf            = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_left_started <= 1'b0;
            r_left_closed  <= 1'b0;
            r_pending      <= OP_NONE;
            r_queued       <= OP_NONE;
            r_left         <= '0;
            r_right        <= '0;
            r_dz           <= 1'b0;
            r_ovf          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_left_started <= n_left_started;
            r_left_closed  <= n_left_closed;
            r_pending      <= n_pending;
            r_queued       <= n_queued;
            r_left         <= n_left;
            r_right        <= n_right;
            r_dz           <= n_dz;
            r_ovf          <= n_ovf;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_trig  <= n_trig;
        r_neg   <= n_neg;
        r_digit <= n_digit;
        r_a     <= n_a;
        r_b     <= n_b;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_cnt   <= n_cnt;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // An accepted character always moves the sequencer out of the idle state in the next cycle.
    `LTR_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != S_IDLE, "accepted word did not start the sequencer")

    // The restoring divider keeps its partial remainder below a nonzero divisor.
    `LTR_ASSERT_SAME(a_div_remainder, i_clk, i_rst_n, r_state == S_DIV, (r_b != '0) && (r_hi < (VB+1)'(r_b)), "divider remainder out of range")

    // The multiply loop never runs past the operand width.
    `LTR_ASSERT_SAME(a_mul_count, i_clk, i_rst_n, r_state == S_MUL, r_cnt < CW'(VB), "multiply step count overran")

    // Loading a result clears the expression state and raises the output valid.
    `LTR_ASSERT_NEXT(a_out_clears, i_clk, i_rst_n, out_load, o_out_valid && (r_pending == OP_NONE) && !r_left_started && !r_left_closed && (r_state == S_IDLE), "result load did not restart the expression")

endmodule

/* tb/sv/left_to_right_expression_evaluator_top_test.sv */
// Self-checking testbench for the left-to-right expression evaluator top level.
`timescale 1ns / 1ps

module left_to_right_expression_evaluator_top_test;
    import ltr_eval_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int CLK_PERIOD = 20;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int RANDOM_ITEMS = 1850;
    localparam logic [63:0] MAX_POS = (64'd1 << (VALUE_BITS - 1)) - 64'd1;

    typedef struct packed {
        t_in_word word;
        logic     hold;
    } t_stream_char;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    t_stream_char char_stream[$];
    logic [7:0]   expr_buf[$];
    t_out_word    due_results[$];

    int total_items = 0;
    int items_sent = 0;
    int ends_sent = 0;
    int results_seen = 0;
    int mismatches = 0;

    logic        lhs_started = 1'b0;
    logic        lhs_closed = 1'b0;
    logic [2:0]  op_pending = OP_NONE;
    logic [2:0]  op_queued = OP_NONE;
    logic [63:0] lhs_acc = '0;
    logic [63:0] rhs_acc = '0;
    logic        saw_div_zero = 1'b0;
    logic        saw_saturate = 1'b0;

    left_to_right_expression_evaluator_top #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(o_in_ready),
        .i_in_word(in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_word(o_out_word)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [63:0] magnitude_of(input logic [63:0] x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    function automatic logic [63:0] clamp_value(input logic neg, input logic [63:0] hi,
                                                input logic [63:0] lo);
        logic [63:0] lim;
        logic [63:0] mag;
        lim = neg ? MAX_POS + 64'd1 : MAX_POS;
        mag = lo;
        if (hi != 64'd0 || lo > lim) begin
            saw_saturate = 1'b1;
            mag = lim;
        end
        return neg ? 64'd0 - mag : mag;
    endfunction

    function automatic logic [63:0] add_or_sub(input logic [63:0] a, input logic [63:0] b,
                                               input logic subtract);
        logic        na;
        logic        nb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [64:0] sum;
        na = a[63];
        nb = b[63] ^ subtract;
        ma = magnitude_of(a);
        mb = magnitude_of(b);
        if (na == nb) begin
            sum = {1'b0, ma} + {1'b0, mb};
            return clamp_value(na, {63'd0, sum[64]}, sum[63:0]);
        end
        if (ma >= mb) begin
            return clamp_value(na, 64'd0, ma - mb);
        end
        return clamp_value(nb, 64'd0, mb - ma);
    endfunction

    function automatic logic [63:0] fixed_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = ({64'd0, magnitude_of(a)} * {64'd0, magnitude_of(b)}) >> FRAC_BITS;
        return clamp_value(a[63] ^ b[63], prod[127:64], prod[63:0]);
    endfunction

    function automatic logic [63:0] fixed_div(input logic [63:0] a, input logic [63:0] b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] quot;
        ma = magnitude_of(a);
        mb = magnitude_of(b);
        if (mb == 64'd0) begin
            saw_div_zero = 1'b1;
            if (ma == 64'd0) begin
                return 64'd0;
            end
            return a[63] ? 64'd0 - (MAX_POS + 64'd1) : MAX_POS;
        end
        quot = ({64'd0, ma} << FRAC_BITS) / {64'd0, mb};
        return clamp_value(a[63] ^ b[63], quot[127:64], quot[63:0]);
    endfunction

    function automatic logic [63:0] shift_in_digit(input logic [63:0] x, input logic [7:0] d);
        logic [127:0] prod;
        logic [63:0]  scaled;
        prod = {64'd0, magnitude_of(x)} * 128'd10;
        scaled = clamp_value(x[63], prod[127:64], prod[63:0]);
        return add_or_sub(scaled, {56'd0, d} << FRAC_BITS, 1'b0);
    endfunction

    function automatic logic [63:0] apply_operator(input logic [2:0] op, input logic [63:0] a,
                                                   input logic [63:0] b);
        case (op)
            OP_ADD: return add_or_sub(a, b, 1'b0);
            OP_SUB: return add_or_sub(a, b, 1'b1);
            OP_MUL: return fixed_mul(a, b);
            OP_DIV: return fixed_div(a, b);
            default: return a;
        endcase
    endfunction

    task automatic eval_char(input t_in_word w);
        logic [7:0] c;
        logic       trigger;
        logic [2:0] op;
        t_out_word  res;
        c = w.char_code;
        trigger = w.last_char;
        case (c)
            CH_PLUS: op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR: op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default: op = OP_NONE;
        endcase
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (lhs_closed) begin
                rhs_acc = shift_in_digit(rhs_acc, c - DIGIT_BASE);
            end else begin
                lhs_started = 1'b1;
                lhs_acc = shift_in_digit(lhs_acc, c - DIGIT_BASE);
            end
        end else if (op != OP_NONE) begin
            if (lhs_closed) begin
                trigger = 1'b1;
            end else begin
                lhs_closed = 1'b1;
            end
            if (op_pending != OP_NONE) begin
                op_queued = op;
            end else begin
                op_pending = op;
            end
        end
        if (lhs_started && op_pending != OP_NONE && trigger) begin
            lhs_acc = apply_operator(op_pending, lhs_acc, rhs_acc);
            op_pending = op_queued;
            rhs_acc = '0;
        end
        if (w.last_char) begin
            res.value = lhs_acc[VALUE_BITS-1:0];
            res.div_zero = saw_div_zero;
            res.overflowed = saw_saturate;
            due_results.push_back(res);
            lhs_started = 1'b0;
            lhs_closed = 1'b0;
            op_pending = OP_NONE;
            op_queued = OP_NONE;
            lhs_acc = '0;
            rhs_acc = '0;
            saw_div_zero = 1'b0;
            saw_saturate = 1'b0;
        end
    endtask

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic int idle_pct(input bit sender);
        int phase;
        phase = (total_items == 0) ? 0 : (items_sent * 3) / total_items;
        if (phase == 0) begin
            return sender ? 14 : 75;
        end
        if (phase == 1) begin
            return sender ? 75 : 14;
        end
        return 0;
    endfunction

    function automatic logic [7:0] op_char();
        case ($urandom_range(3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS
                || c == CH_STAR || c == CH_SLASH) begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            expr_buf.push_back(s[i]);
        end
    endtask

    task automatic flush_expression(input bit hold);
        t_stream_char sc;
        for (int i = 0; i < expr_buf.size(); i++) begin
            sc.word.char_code = expr_buf[i];
            sc.word.last_char = (i == expr_buf.size() - 1);
            sc.hold = hold && (i == 0);
            char_stream.push_back(sc);
        end
        expr_buf.delete();
    endtask

    task automatic add_random_expression(input bit hold);
        int n_operands;
        int n_digits;
        if ($urandom_range(99) < 12) begin
            n_digits = $urandom_range(8, 1);
            for (int j = 0; j < n_digits; j++) begin
                if ($urandom_range(1) == 1) begin
                    expr_buf.push_back(8'($urandom_range(255)));
                end else begin
                    expr_buf.push_back(8'($urandom_range(57, 40)));
                end
            end
        end else begin
            if ($urandom_range(99) < 5) begin
                expr_buf.push_back(op_char());
            end
            n_operands = $urandom_range(5, 1);
            for (int k = 0; k < n_operands; k++) begin
                if (k != 0) begin
                    expr_buf.push_back(op_char());
                    if ($urandom_range(99) < 5) begin
                        expr_buf.push_back(op_char());
                    end
                end
                if (k != 0 && $urandom_range(99) < 10) begin
                    expr_buf.push_back(CH_ZERO);
                end else begin
                    n_digits = ($urandom_range(99) < 15) ? $urandom_range(11, 5)
                                                         : $urandom_range(4, 1);
                    for (int j = 0; j < n_digits; j++) begin
                        expr_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
                        if ($urandom_range(99) < 3) begin
                            expr_buf.push_back(junk_char());
                        end
                    end
                end
                if ($urandom_range(99) < 8) begin
                    expr_buf.push_back(junk_char());
                end
            end
            if ($urandom_range(99) < 8) begin
                expr_buf.push_back(op_char());
            end
            if ($urandom_range(99) < 5) begin
                expr_buf.push_back(junk_char());
            end
        end
        flush_expression(hold);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (in_valid) begin
                if (char_stream[0].word.last_char) begin
                    ends_sent++;
                end
                char_stream.delete(0);
                items_sent++;
            end
            if (char_stream.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)
                    && !(char_stream[0].hold && ends_sent != results_seen)) begin
                in_valid <= 1'b1;
                in_word <= char_stream[0].word;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    flag_error($sformatf("unexpected word: value %0d div_zero %0b overflowed %0b",
                        o_out_word.value, o_out_word.div_zero, o_out_word.overflowed));
                end else begin
                    want = due_results.pop_front();
                    if (o_out_word.value !== want.value || o_out_word.div_zero !== want.div_zero
                            || o_out_word.overflowed !== want.overflowed) begin
                        flag_error($sformatf({"mismatch: expected value %0d div_zero %0b ",
                            "overflowed %0b, got value %0d div_zero %0b overflowed %0b"},
                            want.value, want.div_zero, want.overflowed, o_out_word.value,
                            o_out_word.div_zero, o_out_word.overflowed));
                    end
                end
            end
            if (in_valid && o_in_ready) begin
                eval_char(in_word);
            end
            out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    initial begin
        int n_expr;
        put_text("12+3");
        flush_expression(1'b0);
        put_text("5-9/0");
        flush_expression(1'b0);
        put_text("7*6/4");
        flush_expression(1'b0);
        put_text("/");
        flush_expression(1'b0);
        put_text("6");
        expr_buf.push_back(8'h00);
        put_text("+");
        flush_expression(1'b0);
        put_text("4");
        expr_buf.push_back(8'hFF);
        flush_expression(1'b0);
        put_text("0/0");
        flush_expression(1'b0);
        n_expr = 0;
        while (char_stream.size() < RANDOM_ITEMS) begin
            add_random_expression(n_expr % 50 == 0);
            n_expr++;
        end
        total_items = char_stream.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_stream.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        while (due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (150) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ltr_eval_pkg.sv
rtl/core/left_to_right_expression_evaluator_top.sv
tb/sv/left_to_right_expression_evaluator_top_test.sv
